// File: rtl/saes_pkg.sv
package saes_pkg;

   // operation codes
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // nibble substitution tables
   localparam logic [3:0] SBOX_FWD [16] = '{
      4'd9, 4'd4, 4'd10, 4'd11, 4'd13, 4'd1, 4'd8, 4'd5,
      4'd6, 4'd2, 4'd0, 4'd3, 4'd12, 4'd14, 4'd15, 4'd7
   };
   localparam logic [3:0] SBOX_INV [16] = '{
      4'd10, 4'd5, 4'd9, 4'd11, 4'd1, 4'd7, 4'd8, 4'd15,
      4'd6, 4'd0, 4'd2, 4'd3, 4'd12, 4'd4, 4'd13, 4'd14
   };

   // key schedule round constants
   localparam logic [7:0] RCON_1 = 8'h80;
   localparam logic [7:0] RCON_2 = 8'h30;

   // mix column coefficients (diagonal, off-diagonal)
   localparam logic [3:0] MIX_DIAG     = 4'd1;
   localparam logic [3:0] MIX_OFF      = 4'd4;
   localparam logic [3:0] INV_MIX_DIAG = 4'd9;
   localparam logic [3:0] INV_MIX_OFF  = 4'd2;

   typedef struct packed {
      logic [15:0] k0;
      logic [15:0] k1;
      logic [15:0] k2;
   } round_keys_type;

   // forward substitution on all four nibbles
   function automatic logic [15:0] sub_nibbles(input logic [15:0] v);
      logic [15:0] r;
      for (int i = 0; i < 4; i++) begin
         r[4*i +: 4] = SBOX_FWD[v[4*i +: 4]];
      end
      return r;
   endfunction

   // inverse substitution on all four nibbles
   function automatic logic [15:0] inv_sub_nibbles(input logic [15:0] v);
      logic [15:0] r;
      for (int i = 0; i < 4; i++) begin
         r[4*i +: 4] = SBOX_INV[v[4*i +: 4]];
      end
      return r;
   endfunction

   // swap second and fourth nibble (self-inverse)
   function automatic logic [15:0] shift_rows(input logic [15:0] v);
      return {v[15:12], v[3:0], v[7:4], v[11:8]};
   endfunction

   // product in GF(2^4) modulo x^4 + x + 1
   function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
      logic [3:0] acc;
      logic [3:0] aa;
      acc = 4'h0;
      aa  = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) begin
            acc = acc ^ aa;
         end
         aa = {aa[2:0], 1'b0} ^ (aa[3] ? 4'h3 : 4'h0);
      end
      return acc;
   endfunction

   // column mix with a symmetric 2x2 matrix [d o; o d]
   function automatic logic [15:0] mix_with(input logic [15:0] v, input logic [3:0] d,
                                            input logic [3:0] o);
      logic [15:0] r;
      r[15:12] = gf_mul(d, v[15:12]) ^ gf_mul(o, v[11:8]);
      r[11:8]  = gf_mul(o, v[15:12]) ^ gf_mul(d, v[11:8]);
      r[7:4]   = gf_mul(d, v[7:4])   ^ gf_mul(o, v[3:0]);
      r[3:0]   = gf_mul(o, v[7:4])   ^ gf_mul(d, v[3:0]);
      return r;
   endfunction

   // rotate, substitute and add round constant to one key word
   function automatic logic [7:0] key_g(input logic [7:0] w, input logic [7:0] rc);
      logic [7:0] rot;
      rot = {w[3:0], w[7:4]};
      return {SBOX_FWD[rot[7:4]], SBOX_FWD[rot[3:0]]} ^ rc;
   endfunction

   // expand the cipher key into three round keys
   function automatic round_keys_type expand_key(input logic [15:0] key);
      round_keys_type rk;
      logic [7:0] w2;
      logic [7:0] w3;
      logic [7:0] w4;
      w2    = key[15:8] ^ key_g(key[7:0], RCON_1);
      w3    = w2 ^ key[7:0];
      w4    = w2 ^ key_g(w3, RCON_2);
      rk.k0 = key;
      rk.k1 = {w2, w3};
      rk.k2 = {w4, w4 ^ w3};
      return rk;
   endfunction

endpackage

// File: rtl/saes_key_sched.sv
module saes_key_sched
   import saes_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wr_en,
   input  logic [15:0]    csr_wr_data,
   output round_keys_type round_keys
);

   round_keys_type round_keys_ff;
   round_keys_type round_keys_in;

   // expand at write time so the datapath sees registered round keys
   always_comb begin
      round_keys_in = round_keys_ff;
      if (csr_wr_en) begin
         round_keys_in = expand_key(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_keys_ff <= expand_key(16'h0000);
      end else begin
         round_keys_ff <= round_keys_in;
      end
   end

   assign round_keys = round_keys_ff;

endmodule

// File: rtl/saes_block_cipher_core.sv
// channel | ports                                        | direction
// ------- | -------------------------------------------- | ---------
// request | req_valid, req_stall, req_operation, req_data_block | in
// result  | rsp_valid, rsp_stall, rsp_result_block       | out
// config  | csr_wr_en, csr_wr_data                       | in
//
// three register stages, one item per cycle while the result side is not stalled
// round keys are expanded and registered when the key is written
// synchronous reset empties the pipeline and loads the round keys of key zero
// each stage moves when it is empty or its successor moves, so bubbles close up
// req_stall is high only while all three stages are full and the result is stalled
module saes_block_cipher_core
   import saes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_data_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_block,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   round_keys_type rk;

   logic        vld1_ff, vld2_ff, vld3_ff;
   logic        vld1_in, vld2_in, vld3_in;
   logic        op1_ff, op2_ff;
   logic        op1_in, op2_in;
   logic [15:0] data1_ff, data2_ff, data3_ff;
   logic [15:0] data1_in, data2_in, data3_in;
   logic        load1, load2, load3;

   // key schedule
   saes_key_sched u_key_sched (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .round_keys  (rk)
   );

   // stage load enables
   assign load3     = !vld3_ff || !rsp_stall;
   assign load2     = !vld2_ff || load3;
   assign load1     = !vld1_ff || load2;
   assign req_stall = !load1;

   // stage 1: first key add, first substitution layer and row shift
   always_comb begin
      vld1_in  = load1 ? req_valid : vld1_ff;
      op1_in   = op1_ff;
      data1_in = data1_ff;
      if (load1) begin
         op1_in = req_operation;
         if (req_operation == OP_ENCRYPT) begin
            data1_in = shift_rows(sub_nibbles(req_data_block ^ rk.k0));
         end else begin
            data1_in = inv_sub_nibbles(shift_rows(req_data_block ^ rk.k2));
         end
      end
   end

   // stage 2: column mix and middle key add
   always_comb begin
      vld2_in  = load2 ? vld1_ff : vld2_ff;
      op2_in   = op2_ff;
      data2_in = data2_ff;
      if (load2) begin
         op2_in = op1_ff;
         if (op1_ff == OP_ENCRYPT) begin
            data2_in = mix_with(data1_ff, MIX_DIAG, MIX_OFF) ^ rk.k1;
         end else begin
            data2_in = mix_with(data1_ff ^ rk.k1, INV_MIX_DIAG, INV_MIX_OFF);
         end
      end
   end

   // stage 3: last substitution layer, row shift and final key add
   always_comb begin
      vld3_in  = load3 ? vld2_ff : vld3_ff;
      data3_in = data3_ff;
      if (load3) begin
         if (op2_ff == OP_ENCRYPT) begin
            data3_in = shift_rows(sub_nibbles(data2_ff)) ^ rk.k2;
         end else begin
            data3_in = inv_sub_nibbles(shift_rows(data2_ff)) ^ rk.k0;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= vld1_in;
         vld2_ff <= vld2_in;
         vld3_ff <= vld3_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op1_ff   <= op1_in;
      op2_ff   <= op2_in;
      data1_ff <= data1_in;
      data2_ff <= data2_in;
      data3_ff <= data3_in;
   end

   assign rsp_valid        = vld3_ff;
   assign rsp_result_block = data3_ff;

endmodule

// File: rtl/saes_checker.sv
module saes_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_result_block
);

   // pipeline is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_block))
      else $error("stalled result changed");

   // an accepted item is followed by a valid result on the result side
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##2 rsp_valid)
      else $error("no result three cycles after an accepted item");

   // input backs up only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

endmodule

bind saes_block_cipher_core saes_checker u_saes_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_block (rsp_result_block)
);

// File: test/saes_block_cipher_core_tb.sv
`timescale 1ns / 100ps

module saes_block_cipher_core_tb;
   import saes_pkg::*;

   // nibble substitution tables, entry 0 in the low nibble
   localparam logic [63:0] FWD_NIBS = 64'h7FEC_3026_581D_BA49;
   localparam logic [63:0] INV_NIBS = 64'hED4C_3206_F871_B95A;

   // key expansion round constants
   localparam logic [7:0] RC_FIRST  = 8'h80;
   localparam logic [7:0] RC_SECOND = 8'h30;

   // pause after the last result before a key write or the end
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic        op;
      logic [15:0] data;
      logic [15:0] block;
   } cipher_item_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_ENCRYPT;
   logic [15:0] req_data_block = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_result_block;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   logic [15:0]     key_now = 16'h0000;
   cipher_item_type pending_blocks[$];
   int              error_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_request = 0;

   saes_block_cipher_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_data_block  (req_data_block),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_block(rsp_result_block),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // exact product in GF(2^4) modulo x^4 + x + 1
   function automatic logic [3:0] gf4_times(input logic [3:0] a, input logic [3:0] b);
      logic [6:0] poly;
      poly = 7'd0;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) begin
            poly = poly ^ (7'(a) << i);
         end
      end
      for (int i = 6; i >= 4; i--) begin
         if (poly[i]) begin
            poly = poly ^ (7'b0010011 << (i - 4));
         end
      end
      return poly[3:0];
   endfunction

   function automatic logic [3:0] box_lookup(input logic [63:0] nibs, input logic [3:0] idx);
      return nibs[{idx, 2'b00} +: 4];
   endfunction

   function automatic logic [15:0] nib_sub(input logic [15:0] v, input logic [63:0] nibs);
      return {box_lookup(nibs, v[15:12]), box_lookup(nibs, v[11:8]),
              box_lookup(nibs, v[7:4]), box_lookup(nibs, v[3:0])};
   endfunction

   // second and fourth nibble trade places
   function automatic logic [15:0] nib_swap(input logic [15:0] v);
      return {v[15:12], v[3:0], v[7:4], v[11:8]};
   endfunction

   function automatic logic [15:0] column_mix(input logic [15:0] v, input logic [3:0] d,
                                              input logic [3:0] o);
      return {gf4_times(d, v[15:12]) ^ gf4_times(o, v[11:8]),
              gf4_times(o, v[15:12]) ^ gf4_times(d, v[11:8]),
              gf4_times(d, v[7:4]) ^ gf4_times(o, v[3:0]),
              gf4_times(o, v[7:4]) ^ gf4_times(d, v[3:0])};
   endfunction

   // rotate the key word, substitute both nibbles, add the round constant
   function automatic logic [7:0] round_word(input logic [7:0] w, input logic [7:0] rc);
      return {box_lookup(FWD_NIBS, w[3:0]), box_lookup(FWD_NIBS, w[7:4])} ^ rc;
   endfunction

   function automatic logic [15:0] cipher_block(input logic op, input logic [15:0] data,
                                                input logic [15:0] key);
      logic [7:0]  w2;
      logic [7:0]  w3;
      logic [7:0]  w4;
      logic [15:0] rk0;
      logic [15:0] rk1;
      logic [15:0] rk2;
      logic [15:0] v;
      w2  = key[15:8] ^ round_word(key[7:0], RC_FIRST);
      w3  = w2 ^ key[7:0];
      w4  = w2 ^ round_word(w3, RC_SECOND);
      rk0 = key;
      rk1 = {w2, w3};
      rk2 = {w4, w4 ^ w3};
      v   = data;
      if (op == OP_DECRYPT) begin
         v = nib_sub(nib_swap(v ^ rk2), INV_NIBS);
         v = column_mix(v ^ rk1, 4'd9, 4'd2);
         v = nib_sub(nib_swap(v), INV_NIBS) ^ rk0;
      end else begin
         v = column_mix(nib_swap(nib_sub(v ^ rk0, FWD_NIBS)), 4'd1, 4'd4);
         v = nib_swap(nib_sub(v ^ rk1, FWD_NIBS)) ^ rk2;
      end
      return v;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < 100) begin
         $display("%0t: %s", $realtime, what);
      end
      error_count++;
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("[saes_block_cipher_core] ERROR");
      $finish;
   end

   // result side stall: random, or a long hold when one is requested
   always @(posedge clock) begin : rsp_stall_gen
      int hold_left;
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // key tracking, result check, then prediction of each accepted item
   always @(posedge clock) begin : result_check
      cipher_item_type want;
      cipher_item_type got_in;
      if (!reset) begin
         if (csr_wr_en) begin
            key_now <= csr_wr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_blocks.size() == 0) begin
               report_mismatch($sformatf("result %h with no item outstanding",
                                         rsp_result_block));
            end else begin
               want = pending_blocks.pop_front();
               if (rsp_result_block !== want.block) begin
                  report_mismatch($sformatf("op %0d data %h: result %h, predicted %h",
                                            want.op, want.data, rsp_result_block,
                                            want.block));
               end
            end
         end
         if (req_valid && !req_stall) begin
            got_in.op    = req_operation;
            got_in.data  = req_data_block;
            got_in.block = cipher_block(req_operation, req_data_block, key_now);
            pending_blocks.push_back(got_in);
         end
      end
   end

   // offer one item, with random idle cycles first, and return once it is taken
   task automatic send_item(input logic op, input logic [15:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_data_block <= data;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // stop offering, wait for every result, then let the pipeline settle
   task automatic drain_results;
      req_valid <= 1'b0;
      // wait for the clock so the last accepted item is already queued
      @(posedge clock);
      while (pending_blocks.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_key(input logic [15:0] key);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= key;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [15:0] random_block;
      case ($urandom_range(15))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h0001 << $urandom_range(15);
         3:       return ~(16'h0001 << $urandom_range(15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_key;
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // key zero after reset, never written
   task automatic test_reset_key;
      send_item(OP_ENCRYPT, 16'h0000);
      send_item(OP_DECRYPT, 16'hFFFF);
   endtask

   // extreme and mixed keys and blocks, both operations
   task automatic test_directed_corners;
      load_key(16'hFFFF);
      send_item(OP_ENCRYPT, 16'h0000);
      send_item(OP_DECRYPT, 16'h0000);
      send_item(OP_ENCRYPT, 16'hFFFF);
      send_item(OP_DECRYPT, 16'hFFFF);
      load_key(16'h4AF5);
      send_item(OP_ENCRYPT, 16'hD728);
      send_item(OP_DECRYPT, 16'h24EC);
      send_item(OP_ENCRYPT, 16'h8000);
      send_item(OP_DECRYPT, 16'h0001);
      load_key(16'hA73B);
      send_item(OP_ENCRYPT, 16'h6F6B);
      send_item(OP_DECRYPT, 16'h0738);
      load_key(16'h0000);
      send_item(OP_ENCRYPT, 16'hFFFF);
      send_item(OP_DECRYPT, 16'h0000);
      send_item(OP_ENCRYPT, 16'h5555);
      send_item(OP_DECRYPT, 16'hAAAA);
   endtask

   // random items in groups, a new key between groups once all results are back
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int count);
      int sent;
      int group_len;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < count) begin
         load_key(random_key());
         group_len = $urandom_range(20, 120);
         for (int i = 0; i < group_len && sent < count; i++) begin
            send_item(1'($urandom), random_block());
            sent++;
         end
      end
   endtask

   // long result hold while items keep coming, so the input side stalls
   task automatic test_input_backpressure;
      drain_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 150;
      for (int i = 0; i < 40; i++) begin
         send_item(1'($urandom), random_block());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_key();
      test_directed_corners();
      test_random_traffic(27, 82, 430);
      test_random_traffic(82, 27, 430);
      test_random_traffic(0, 0, 430);
      test_input_backpressure();
      drain_results();
      if (error_count == 0) begin
         $display("[saes_block_cipher_core] OK");
      end else begin
         $display("[saes_block_cipher_core] ERROR");
      end
      $finish;
   end

endmodule
